/* src/cdq_pkg.sv */
// Shared types and constants for the circular deque unit.
package cdq_pkg;

    // Width of the data fields on the ports
    localparam int unsigned FIELD_W = 32;
    // Width of the capacity register and of the fill count
    localparam int unsigned COUNT_W = 7;
    // Capacity after reset
    localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

    // Operation codes carried by func
    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_QUERY      = 3'd4
    } t_func;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // One result, as staged and as presented on the output
    typedef struct packed {
        logic               ok;
        logic [FIELD_W-1:0] front;
        logic [FIELD_W-1:0] rear;
        logic               empty;
        logic               full;
        logic [COUNT_W-1:0] count;
    } t_result;

    // Write and read request from the sequencer to the ring memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

/* src/cdq_ring_mem.sv */
// Ring store: one write port and one read port with registered read data.
module cdq_ring_mem #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned AW         = 6
) (
    input  logic                  i_clk,
    input  cdq_pkg::t_mem_ctl     i_ctl,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered read data
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/circular_deque_unit.sv */
// Circular deque unit: double-ended queue held in a ring memory.
// Each request is one operation (push front, push back, pop front, pop back,
// query) and gives exactly one result with the success flag, the front and
// rear words, the empty and full flags and the fill count after the operation.
// Front and rear words are kept in registers beside the ring memory, so pushes,
// queries, refused operations and pops that leave the deque empty finish in
// the cycle they are accepted, and a new request can follow in the next cycle
// unless the staging register is full and the output side stalls. A pop that
// leaves entries behind reads the newly exposed end word from the registered
// ring read port and passes through the read state before the next request is
// accepted. A result waits in a staging register, then the output register, so
// one more request can be taken while the output side stalls. Writing capacity
// (0 is taken as 1, values above DEPTH as DEPTH) empties the deque; the user
// must write it only while idle (not enforced). Empty deques report zero front and rear.
module circular_deque_unit #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [6:0]         i_cfg_capacity,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_ok,
    output logic signed [31:0] o_front_value,
    output logic signed [31:0] o_rear_value,
    output logic               o_is_empty,
    output logic               o_is_full,
    output logic [6:0]         o_fill_count
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = cdq_pkg::COUNT_W;
    localparam int unsigned PW = (IW > CW) ? IW : CW;
    localparam int unsigned FW = cdq_pkg::FIELD_W;

    // Effective capacity: clamp to 1..DEPTH
    function automatic logic [CW-1:0] f_eff_cap(input logic [CW-1:0] cap);
        logic [CW-1:0] res;
        begin
            if (cap == '0) begin
                res = CW'(1);
            end else if (32'(cap) > DEPTH) begin
                res = CW'(DEPTH);
            end else begin
                res = cap;
            end
            f_eff_cap = res;
        end
    endfunction

    // Ring index step forward with wrap at the last index in use
    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] idx,
                                             input logic [PW-1:0] last_idx);
        logic [PW-1:0] w;
        begin
            w = PW'(idx);
            f_next = (w == last_idx) ? '0 : IW'(w + PW'(1));
        end
    endfunction

    // Ring index step backward with wrap to the last index in use
    function automatic logic [IW-1:0] f_prev(input logic [IW-1:0] idx,
                                             input logic [PW-1:0] last_idx);
        logic [PW-1:0] w;
        begin
            w = PW'(idx);
            f_prev = (w == '0) ? IW'(last_idx) : IW'(w - PW'(1));
        end
    endfunction

    // Stored word to port width, zero extended or truncated
    function automatic logic [FW-1:0] f_to_port(input logic [DATA_WIDTH-1:0] d);
        f_to_port = FW'({{FW{1'b0}}, d});
    endfunction

    // Deque state
    cdq_pkg::t_state       r_state, n_state;
    logic [IW-1:0]         r_head, n_head;
    logic [IW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_cap;
    logic [DATA_WIDTH-1:0] r_front, n_front;
    logic [DATA_WIDTH-1:0] r_rear, n_rear;
    logic                  r_fill_front, n_fill_front;

    // Result staging and output registers
    logic                  r_res_valid, n_res_valid;
    cdq_pkg::t_result      r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    cdq_pkg::t_result      r_out, n_out;

    // Memory side
    cdq_pkg::t_mem_ctl     mem_ctl;
    logic [IW-1:0]         wr_addr;
    logic [IW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] store_word;
    logic [DATA_WIDTH-1:0] rd_data;

    logic                  in_acc;
    logic                  cfg_acc;
    logic                  out_free;
    logic [PW-1:0]         cap_last;
    logic                  not_full;
    logic                  not_empty;
    logic                  op_ok;
    logic                  need_rd;
    logic [IW-1:0]         idx_tmp;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == cdq_pkg::ST_IDLE) && (!r_res_valid || out_free);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign cap_last    = PW'(r_cap) - PW'(1);
    assign not_full    = (r_count != r_cap);
    assign not_empty   = (r_count != '0);
    assign store_word  = DATA_WIDTH'({{DATA_WIDTH{1'b0}}, $unsigned(i_value)});

    cdq_ring_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (IW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_ctl      (mem_ctl),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (store_word),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data)
    );

    // Sequencer: decode, update pointers, issue memory accesses, stage result
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_front      = r_front;
        n_rear       = r_rear;
        n_fill_front = r_fill_front;
        n_res        = r_res;
        n_res_valid  = r_res_valid && !out_free;
        mem_ctl      = '0;
        wr_addr      = r_tail;
        rd_addr      = r_head;
        op_ok        = 1'b0;
        need_rd      = 1'b0;
        idx_tmp      = r_tail;

        unique case (r_state)
            cdq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (cdq_pkg::t_func'(i_func))
                        cdq_pkg::FN_PUSH_FRONT: begin
                            if (not_full) begin
                                idx_tmp       = f_prev(r_head, cap_last);
                                mem_ctl.wr_en = 1'b1;
                                wr_addr       = idx_tmp;
                                n_head        = idx_tmp;
                                n_count       = r_count + CW'(1);
                                n_front       = store_word;
                                if (!not_empty) begin
                                    n_rear = store_word;
                                end
                                op_ok = 1'b1;
                            end
                        end
                        cdq_pkg::FN_PUSH_BACK: begin
                            if (not_full) begin
                                mem_ctl.wr_en = 1'b1;
                                wr_addr       = r_tail;
                                n_tail        = f_next(r_tail, cap_last);
                                n_count       = r_count + CW'(1);
                                n_rear        = store_word;
                                if (!not_empty) begin
                                    n_front = store_word;
                                end
                                op_ok = 1'b1;
                            end
                        end
                        cdq_pkg::FN_POP_FRONT: begin
                            if (not_empty) begin
                                n_head  = f_next(r_head, cap_last);
                                n_count = r_count - CW'(1);
                                op_ok   = 1'b1;
                                // new front must come from the ring
                                if (r_count != CW'(1)) begin
                                    need_rd       = 1'b1;
                                    mem_ctl.rd_en = 1'b1;
                                    rd_addr       = n_head;
                                    n_fill_front  = 1'b1;
                                end
                            end
                        end
                        cdq_pkg::FN_POP_BACK: begin
                            if (not_empty) begin
                                idx_tmp = f_prev(r_tail, cap_last);
                                n_tail  = idx_tmp;
                                n_count = r_count - CW'(1);
                                op_ok   = 1'b1;
                                // new rear sits one below the new tail
                                if (r_count != CW'(1)) begin
                                    need_rd       = 1'b1;
                                    mem_ctl.rd_en = 1'b1;
                                    rd_addr       = f_prev(idx_tmp, cap_last);
                                    n_fill_front  = 1'b0;
                                end
                            end
                        end
                        cdq_pkg::FN_QUERY: begin
                            op_ok = 1'b1;
                        end
                        default: begin
                            // undefined code: query without success
                            op_ok = 1'b0;
                        end
                    endcase

                    if (need_rd) begin
                        n_state = cdq_pkg::ST_READ;
                    end else begin
                        n_res_valid = 1'b1;
                        n_res.ok    = op_ok;
                        n_res.count = n_count;
                        n_res.empty = (n_count == '0);
                        n_res.full  = (n_count == r_cap);
                        n_res.front = (n_count == '0) ? '0 : f_to_port(n_front);
                        n_res.rear  = (n_count == '0) ? '0 : f_to_port(n_rear);
                    end
                end
            end
            cdq_pkg::ST_READ: begin
                // refill the exposed end from the ring read
                if (r_fill_front) begin
                    n_front = rd_data;
                end else begin
                    n_rear = rd_data;
                end
                n_res_valid = 1'b1;
                n_res.ok    = 1'b1;
                n_res.count = r_count;
                n_res.empty = 1'b0;
                n_res.full  = (r_count == r_cap);
                n_res.front = f_to_port(n_front);
                n_res.rear  = f_to_port(n_rear);
                n_state     = cdq_pkg::ST_IDLE;
            end
            default: begin
                n_state = cdq_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register loads from the staging register when free
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (out_free) begin
            n_out_valid = r_res_valid;
            n_out       = r_res;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdq_pkg::ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_cap       <= f_eff_cap(cdq_pkg::CAP_RESET);
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_out_valid <= n_out_valid;
            if (cfg_acc) begin
                // capacity write empties the deque
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
                r_cap   <= f_eff_cap(i_cfg_capacity);
            end else begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_front      <= n_front;
        r_rear       <= n_rear;
        r_fill_front <= n_fill_front;
        r_res        <= n_res;
        r_out        <= n_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_out.ok;
    assign o_front_value = $signed(r_out.front);
    assign o_rear_value  = $signed(r_out.rear);
    assign o_is_empty    = r_out.empty;
    assign o_is_full     = r_out.full;
    assign o_fill_count  = r_out.count;

endmodule

/* verif/cdq_checker.sv */
// Result checker for the circular deque unit: predicts every result and compares it.
`timescale 1ns / 100ps

module cdq_checker #(
    parameter int unsigned DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [6:0]         i_cfg_capacity,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_func,
    input  logic [31:0]        i_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_ok,
    input  logic [31:0]        i_front_value,
    input  logic [31:0]        i_rear_value,
    input  logic               i_is_empty,
    input  logic               i_is_full,
    input  logic [6:0]         i_fill_count,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int unsigned CW = cdq_pkg::COUNT_W;

    // Shadow copy of the deque
    logic [cdq_pkg::FIELD_W-1:0] ring_words [DEPTH];
    logic [CW-1:0]               cap_reg;
    int unsigned                 head_pos;
    int unsigned                 tail_pos;
    int unsigned                 held;
    int unsigned                 ecap;

    // Predicted results, oldest first
    cdq_pkg::t_result            due_results [$];
    cdq_pkg::t_result            want;
    cdq_pkg::t_result            seen;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cap_reg  = cdq_pkg::CAP_RESET;
            head_pos = 0;
            tail_pos = 0;
            held     = 0;
            due_results.delete();
        end else begin
            // capacity write empties the deque
            if (i_cfg_valid && i_cfg_ready) begin
                cap_reg  = i_cfg_capacity;
                head_pos = 0;
                tail_pos = 0;
                held     = 0;
            end

            // predict the result of each accepted request
            if (i_in_valid && i_in_ready) begin
                // 0 counts as one entry, anything above DEPTH as DEPTH
                ecap = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
                want = '0;
                case (cdq_pkg::t_func'(i_func))
                    cdq_pkg::FN_PUSH_FRONT: begin
                        if (held < ecap) begin
                            head_pos = (head_pos == 0) ? ecap - 1 : head_pos - 1;
                            ring_words[head_pos] = i_value;
                            held++;
                            want.ok = 1'b1;
                        end
                    end
                    cdq_pkg::FN_PUSH_BACK: begin
                        if (held < ecap) begin
                            ring_words[tail_pos] = i_value;
                            tail_pos = (tail_pos + 1 >= ecap) ? 0 : tail_pos + 1;
                            held++;
                            want.ok = 1'b1;
                        end
                    end
                    cdq_pkg::FN_POP_FRONT: begin
                        if (held > 0) begin
                            head_pos = (head_pos + 1 >= ecap) ? 0 : head_pos + 1;
                            held--;
                            want.ok = 1'b1;
                        end
                    end
                    cdq_pkg::FN_POP_BACK: begin
                        if (held > 0) begin
                            tail_pos = (tail_pos == 0) ? ecap - 1 : tail_pos - 1;
                            held--;
                            want.ok = 1'b1;
                        end
                    end
                    cdq_pkg::FN_QUERY: begin
                        want.ok = 1'b1;
                    end
                    // undefined codes read like a query but report failure
                    default: ;
                endcase
                // front and rear stay zero on an empty deque
                if (held > 0) begin
                    want.front = ring_words[head_pos];
                    want.rear  = ring_words[(tail_pos == 0) ? ecap - 1 : tail_pos - 1];
                end
                want.empty = (held == 0);
                want.full  = (held == ecap);
                want.count = CW'(held);
                due_results.push_back(want);
            end

            // compare each accepted result with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                seen.ok    = i_ok;
                seen.front = i_front_value;
                seen.rear  = i_rear_value;
                seen.empty = i_is_empty;
                seen.full  = i_is_full;
                seen.count = i_fill_count;
                if (due_results.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (seen.ok !== want.ok) begin
                        $error("ok: expected %0b, got %0b", want.ok, seen.ok);
                        o_fail_count++;
                    end
                    if (seen.front !== want.front) begin
                        $error("front_value: expected %h, got %h", want.front, seen.front);
                        o_fail_count++;
                    end
                    if (seen.rear !== want.rear) begin
                        $error("rear_value: expected %h, got %h", want.rear, seen.rear);
                        o_fail_count++;
                    end
                    if (seen.empty !== want.empty) begin
                        $error("is_empty: expected %0b, got %0b", want.empty, seen.empty);
                        o_fail_count++;
                    end
                    if (seen.full !== want.full) begin
                        $error("is_full: expected %0b, got %0b", want.full, seen.full);
                        o_fail_count++;
                    end
                    if (seen.count !== want.count) begin
                        $error("fill_count: expected %0d, got %0d", want.count, seen.count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = due_results.size();
    end

endmodule

/* verif/circular_deque_unit_tb.sv */
// Testbench top for the circular deque unit: stimulus, flow control and the verdict.
`timescale 1ns / 100ps

module circular_deque_unit_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AFTER  = 400;    // results taken before the long hold-off
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 34;
    localparam int PHASES      = 10;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic [6:0]         cfg_capacity = '0;
    logic               in_valid     = 1'b0;
    logic [2:0]         func         = cdq_pkg::FN_QUERY;
    logic signed [31:0] value        = '0;
    logic               out_ready    = 1'b0;

    logic               cfg_ready;
    logic               in_ready;
    logic               out_valid;
    logic               ok;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic               is_empty;
    logic               is_full;
    logic [6:0]         fill_count;

    int                 fail_count;
    int                 pending;

    // no idling on either side while set
    bit                 burst    = 1'b0;
    int                 taken    = 0;
    bit                 held_off = 1'b0;

    // capacity and request count per random phase; one entry is drawn at run time
    logic [6:0] phase_cap [PHASES] = '{7'd64, 7'd1, 7'd3, 7'd127, 7'd5,
                                       7'd0, 7'd2, 7'd12, 7'd65, 7'd17};
    int         phase_ops [PHASES] = '{120, 50, 60, 110, 70, 40, 50, 80, 90, 80};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    circular_deque_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_capacity (cfg_capacity),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (func),
        .i_value        (value),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_ok           (ok),
        .o_front_value  (front_value),
        .o_rear_value   (rear_value),
        .o_is_empty     (is_empty),
        .o_is_full      (is_full),
        .o_fill_count   (fill_count)
    );

    cdq_checker #(.DEPTH(64)) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_capacity (cfg_capacity),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_func         (func),
        .i_value        (value),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_ok           (ok),
        .i_front_value  (front_value),
        .i_rear_value   (rear_value),
        .i_is_empty     (is_empty),
        .i_is_full      (is_full),
        .i_fill_count   (fill_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Offer one request, with random idle cycles ahead of it; returns at acceptance
    task automatic send_op(input logic [2:0] f, input logic [31:0] v);
        @(negedge clk);
        while (!burst && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Capacity write, only on an idle block
    task automatic write_capacity(input logic [6:0] c);
        drain();
        @(negedge clk);
        cfg_valid    <= 1'b1;
        cfg_capacity <= c;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly random words, with the extremes now and then
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 24))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // Growing segments favor pushes, shrinking ones favor pops
    function automatic logic [2:0] pick_op(input bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 3'(cdq_pkg::FN_QUERY + $urandom_range(1, 3));
        if (r < 10)
            return cdq_pkg::FN_QUERY;
        if ((r < 75) == grow)
            return $urandom_range(0, 1) ? cdq_pkg::FN_PUSH_BACK : cdq_pkg::FN_PUSH_FRONT;
        return $urandom_range(0, 1) ? cdq_pkg::FN_POP_BACK : cdq_pkg::FN_POP_FRONT;
    endfunction

    // Result side: random stalls, one long hold-off so the block backs up
    initial begin : result_sink
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                taken++;
            @(negedge clk);
            if (!held_off && taken >= HOLD_AFTER) begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= burst || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int seg_left;
        int ecap;
        bit grow;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset capacity: refusals on empty, extremes, undefined codes
        send_op(cdq_pkg::FN_QUERY, '0);
        send_op(cdq_pkg::FN_POP_FRONT, 32'h1234_5678);
        send_op(cdq_pkg::FN_POP_BACK, '0);
        send_op(cdq_pkg::FN_PUSH_FRONT, 32'h8000_0000);
        send_op(cdq_pkg::FN_PUSH_BACK, 32'h7FFF_FFFF);
        send_op(cdq_pkg::FN_PUSH_BACK, '1);              // all ones is an ordinary word
        send_op(3'(cdq_pkg::FN_QUERY + 1), 32'h5555_5555);
        send_op(3'(cdq_pkg::FN_QUERY + 2), 32'hAAAA_AAAA);
        send_op(3'(cdq_pkg::FN_QUERY + 3), '0);
        send_op(cdq_pkg::FN_POP_FRONT, '0);
        send_op(cdq_pkg::FN_POP_BACK, '0);
        send_op(cdq_pkg::FN_POP_BACK, '0);
        send_op(cdq_pkg::FN_POP_FRONT, '0);

        // capacity 0 acts as a single entry
        write_capacity(7'd0);
        send_op(cdq_pkg::FN_PUSH_BACK, '1);
        send_op(cdq_pkg::FN_PUSH_FRONT, 32'h0000_0001);  // refused, full
        send_op(cdq_pkg::FN_QUERY, '0);
        send_op(cdq_pkg::FN_POP_BACK, '0);

        // two entries: wrap in both directions
        write_capacity(7'd2);
        send_op(cdq_pkg::FN_PUSH_FRONT, 32'hDEAD_BEEF);
        send_op(cdq_pkg::FN_PUSH_FRONT, 32'h0BAD_F00D);
        send_op(cdq_pkg::FN_PUSH_BACK, 32'hFFFF_0000);  // refused, full
        send_op(cdq_pkg::FN_POP_FRONT, '0);
        send_op(cdq_pkg::FN_PUSH_BACK, 32'h0000_FFFF);
        send_op(cdq_pkg::FN_POP_BACK, '0);
        send_op(cdq_pkg::FN_POP_FRONT, '0);

        // random phases across capacities
        phase_cap[7] = 7'($urandom_range(6, 40));
        for (int p = 0; p < PHASES; p++) begin
            write_capacity(phase_cap[p]);
            burst = (p == 3);
            ecap = (phase_cap[p] == 0) ? 1 : ((phase_cap[p] > 64) ? 64 : phase_cap[p]);
            seg_left = 0;
            for (int n = 0; n < phase_ops[p]; n++) begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 2 * ecap + 4);
                    grow = $urandom_range(0, 1);
                end
                seg_left--;
                send_op(pick_op(grow), pick_value());
            end
        end
        burst = 1'b0;

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
